// File: rtl/stwr_pkg.sv
`timescale 1ns / 1ps

package stwr_pkg;

  // field widths
  localparam int SCR_W    = 16;
  localparam int DIST_W   = 20;
  localparam int SIZE_W   = 13;
  localparam int SCALE_W  = 16;
  localparam int ROW_W    = 48;
  localparam int ELEM_W   = 16;
  localparam int POS_W    = 20;
  localparam int CPOS_W   = 60;
  localparam int DIR_W    = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 60;

  // internal widths
  localparam int HALF_W   = SIZE_W - 1;      // half screen size
  localparam int CNUM_W   = 32;              // camera-space numerator magnitude
  localparam int WORLD_W  = 51;              // world vector, 30 fraction bits
  localparam int MAG_W    = WORLD_W - 1;
  localparam int SM_W     = 31;              // block-scaled magnitude
  localparam int SQ_W     = 64;              // sum of squares
  localparam int LEN_W    = 32;              // vector length
  localparam int DQ_W     = 16;              // direction quotient

  // stage counts of the iterative units
  localparam int CDIV_STAGES = CNUM_W;
  localparam int SQRT_STAGES = SQ_W / 2;
  localparam int DDIV_STAGES = DQ_W;

  // input reg, numerator reg, cam divide, 8 vector stages, sqrt, dir divide, 2 point stages
  localparam int LATENCY = 2 + CDIV_STAGES + 8 + SQRT_STAGES + DDIV_STAGES + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0          = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1          = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2          = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_POS       = 4'd7;

endpackage

// File: rtl/stwr_cam_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per pipeline stage.
module stwr_cam_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [stwr_pkg::CNUM_W-1:0] num_i,
  input  logic [stwr_pkg::HALF_W-1:0] den_i,
  output logic                         valid_o,
  output logic [stwr_pkg::CNUM_W-1:0] quo_o
);
  import stwr_pkg::*;

  logic [CDIV_STAGES-1:0] v_q;
  logic [CNUM_W-1:0] num_q [CDIV_STAGES];
  logic [CNUM_W-1:0] num_d [CDIV_STAGES];
  logic [CNUM_W-1:0] quo_q [CDIV_STAGES];
  logic [CNUM_W-1:0] quo_d [CDIV_STAGES];
  logic [HALF_W-1:0] rem_q [CDIV_STAGES];
  logic [HALF_W-1:0] rem_d [CDIV_STAGES];
  logic [HALF_W-1:0] den_q [CDIV_STAGES];
  logic [HALF_W-1:0] den_d [CDIV_STAGES];

  // one shift-subtract step per stage
  always_comb begin
    logic [HALF_W:0]   rem2;
    logic [CNUM_W-1:0] num_s, quo_s;
    logic [HALF_W-1:0] rem_s, den_s;
    logic              ge;
    for (int k = 0; k < CDIV_STAGES; k++) begin
      if (k == 0) begin
        num_s = num_i;
        quo_s = '0;
        rem_s = '0;
        den_s = den_i;
      end else begin
        num_s = num_q[k-1];
        quo_s = quo_q[k-1];
        rem_s = rem_q[k-1];
        den_s = den_q[k-1];
      end
      rem2     = {rem_s, num_s[CNUM_W-1]};
      ge       = (rem2 >= {1'b0, den_s});
      rem_d[k] = ge ? HALF_W'(rem2 - {1'b0, den_s}) : rem2[HALF_W-1:0];
      quo_d[k] = {quo_s[CNUM_W-2:0], ge};
      num_d[k] = {num_s[CNUM_W-2:0], 1'b0};
      den_d[k] = den_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[CDIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CDIV_STAGES; k++) begin
      num_q[k] <= num_d[k];
      quo_q[k] <= quo_d[k];
      rem_q[k] <= rem_d[k];
      den_q[k] <= den_d[k];
    end
  end

  assign valid_o = v_q[CDIV_STAGES-1];
  assign quo_o   = quo_q[CDIV_STAGES-1];

endmodule

// File: rtl/stwr_isqrt.sv
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one result bit per pipeline stage.
module stwr_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [stwr_pkg::SQ_W-1:0]  sum_i,
  output logic                        valid_o,
  output logic [stwr_pkg::LEN_W-1:0] len_o
);
  import stwr_pkg::*;

  logic [SQRT_STAGES-1:0] v_q;
  logic [SQ_W-1:0] x_q   [SQRT_STAGES];
  logic [SQ_W-1:0] x_d   [SQRT_STAGES];
  logic [SQ_W-1:0] res_q [SQRT_STAGES];
  logic [SQ_W-1:0] res_d [SQRT_STAGES];

  // trial subtract of res + bit, bit walking down two places per stage
  always_comb begin
    logic [SQ_W-1:0] x_s, res_s, bitv;
    logic [SQ_W:0]   trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        x_s   = sum_i;
        res_s = '0;
      end else begin
        x_s   = x_q[k-1];
        res_s = res_q[k-1];
      end
      bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      trial = {1'b0, res_s} + {1'b0, bitv};
      if ({1'b0, x_s} >= trial) begin
        x_d[k]   = x_s - trial[SQ_W-1:0];
        res_d[k] = (res_s >> 1) + bitv;
      end else begin
        x_d[k]   = x_s;
        res_d[k] = res_s >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[SQRT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      x_q[k]   <= x_d[k];
      res_q[k] <= res_d[k];
    end
  end

  assign valid_o = v_q[SQRT_STAGES-1];
  assign len_o   = res_q[SQRT_STAGES-1][LEN_W-1:0];

endmodule

// File: rtl/stwr_dir_div.sv
`timescale 1ns / 1ps

// Three-lane divider (mag << 15) / len, one quotient bit per stage.
// Quotient never exceeds 2^15 since each magnitude is at most the length.
module stwr_dir_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [2:0][stwr_pkg::SM_W-1:0]       mag_i,
  input  logic [stwr_pkg::LEN_W-1:0]          den_i,
  output logic                                 valid_o,
  output logic [2:0][stwr_pkg::DQ_W-1:0]       quo_o
);
  import stwr_pkg::*;

  logic [DDIV_STAGES-1:0] v_q;
  logic [2:0][LEN_W-1:0] rem_q [DDIV_STAGES];
  logic [2:0][LEN_W-1:0] rem_d [DDIV_STAGES];
  logic [2:0][DQ_W-1:0]  lo_q  [DDIV_STAGES];
  logic [2:0][DQ_W-1:0]  lo_d  [DDIV_STAGES];
  logic [2:0][DQ_W-1:0]  quo_q [DDIV_STAGES];
  logic [2:0][DQ_W-1:0]  quo_d [DDIV_STAGES];
  logic [LEN_W-1:0]      den_q [DDIV_STAGES];
  logic [LEN_W-1:0]      den_d [DDIV_STAGES];

  always_comb begin
    logic [LEN_W:0]   rem2;
    logic [LEN_W-1:0] rem_s, den_s;
    logic [DQ_W-1:0]  lo_s, quo_s;
    logic             ge;
    for (int k = 0; k < DDIV_STAGES; k++) begin
      den_s    = (k == 0) ? den_i : den_q[k-1];
      den_d[k] = den_s;
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          // upper part of mag << 15 is already below the divisor
          rem_s = {2'b00, mag_i[l][SM_W-1:1]};
          lo_s  = {mag_i[l][0], 15'd0};
          quo_s = '0;
        end else begin
          rem_s = rem_q[k-1][l];
          lo_s  = lo_q[k-1][l];
          quo_s = quo_q[k-1][l];
        end
        rem2        = {rem_s, lo_s[DQ_W-1]};
        ge          = (rem2 >= {1'b0, den_s});
        rem_d[k][l] = ge ? LEN_W'(rem2 - {1'b0, den_s}) : rem2[LEN_W-1:0];
        lo_d[k][l]  = {lo_s[DQ_W-2:0], 1'b0};
        quo_d[k][l] = {quo_s[DQ_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[DDIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DDIV_STAGES; k++) begin
      rem_q[k] <= rem_d[k];
      lo_q[k]  <= lo_d[k];
      quo_q[k] <= quo_d[k];
      den_q[k] <= den_d[k];
    end
  end

  assign valid_o = v_q[DDIV_STAGES-1];
  assign quo_o   = quo_q[DDIV_STAGES-1];

endmodule

// File: rtl/screen_to_world_ray_unit.sv
`timescale 1ns / 1ps

// Camera ray generation. A command (screen_x_i, screen_y_i, distance_i) is
// taken on every clock edge where start_i is high; busy_o is always low, so
// one command per cycle is sustained without gaps.
// The result (unit direction dir_*_o, world point point_*_o) appears for
// exactly one cycle, flagged by done_o, once the command has passed through
// every pipeline stage. Results come out in command order. The stages are
// those of two parallel 32-stage dividers for the screen-to-camera mapping,
// a 32-stage square root and a 16-stage divider for normalization, plus 12
// stages of multiply, add, block scaling and saturation.
// The receiver cannot stall; done_o is a plain strobe.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i on the
// clock edge (indexes beyond 7 are dropped). Write only while no command is
// in flight. Reset clears the pipeline and loads the default camera
// (640x480, unit scale, identity rotation, origin position).
module screen_to_world_ray_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [stwr_pkg::SCR_W-1:0]         screen_x_i,
  input  logic [stwr_pkg::SCR_W-1:0]         screen_y_i,
  input  logic [stwr_pkg::DIST_W-1:0]        distance_i,
  output logic                                done_o,
  output logic signed [stwr_pkg::DIR_W-1:0]  dir_x_o,
  output logic signed [stwr_pkg::DIR_W-1:0]  dir_y_o,
  output logic signed [stwr_pkg::DIR_W-1:0]  dir_z_o,
  output logic signed [stwr_pkg::POS_W-1:0]  point_x_o,
  output logic signed [stwr_pkg::POS_W-1:0]  point_y_o,
  output logic signed [stwr_pkg::POS_W-1:0]  point_z_o,
  input  logic                                cfg_we_i,
  input  logic [stwr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [stwr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import stwr_pkg::*;

  typedef struct packed {
    logic              sgn_x;
    logic              sgn_y;
    logic [DIST_W-1:0] reach;
  } cside_t;

  typedef struct packed {
    logic [2:0]            sgn;
    logic [2:0][SM_W-1:0]  sm;
    logic [DIST_W-1:0]     reach;
  } sside_t;

  typedef struct packed {
    logic [2:0]        sgn;
    logic [DIST_W-1:0] reach;
  } dside_t;

  // ---------------- configuration registers
  logic [SIZE_W-1:0]  width_q, height_q;
  logic [SCALE_W-1:0] scale_x_q, scale_y_q;
  logic [ROW_W-1:0]   row_q [3];
  logic [CPOS_W-1:0]  cpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 13'd640;
      height_q  <= 13'd480;
      scale_x_q <= 16'd4096;
      scale_y_q <= 16'd4096;
      row_q[0]  <= 48'h0000_0000_4000;
      row_q[1]  <= 48'h0000_4000_0000;
      row_q[2]  <= 48'h4000_0000_0000;
      cpos_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCREEN_WIDTH:  width_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: height_q  <= cfg_data_i[SIZE_W-1:0];
        REG_SCALE_X:       scale_x_q <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_Y:       scale_y_q <= cfg_data_i[SCALE_W-1:0];
        REG_ROW0:          row_q[0]  <= cfg_data_i[ROW_W-1:0];
        REG_ROW1:          row_q[1]  <= cfg_data_i[ROW_W-1:0];
        REG_ROW2:          row_q[2]  <= cfg_data_i[ROW_W-1:0];
        REG_CAM_POS:       cpos_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // half sizes, a zero half treated as one
  logic [HALF_W-1:0] hw, hh;
  assign hw = (width_q[SIZE_W-1:1] == '0) ? HALF_W'(1) : width_q[SIZE_W-1:1];
  assign hh = (height_q[SIZE_W-1:1] == '0) ? HALF_W'(1) : height_q[SIZE_W-1:1];

  assign busy_o = 1'b0;

  // ---------------- S0: command register
  logic              v0_q;
  logic [SCR_W-1:0]  sx0_q, sy0_q;
  logic [DIST_W-1:0] dist0_q;

  // ---------------- S1: numerators, magnitude and sign
  logic              v1_q;
  logic [CNUM_W-1:0] nx1_q, ny1_q;
  cside_t            side1_q;

  logic signed [17:0] dx, dy;
  logic [16:0]        adx, ady;
  logic [32:0]        nx_full, ny_full;

  always_comb begin
    dx      = $signed({2'b00, sx0_q}) - $signed({2'b00, hw, 4'b0000});
    dy      = $signed({2'b00, hh, 4'b0000}) - $signed({2'b00, sy0_q});
    adx     = dx[17] ? 17'(-dx) : dx[16:0];
    ady     = dy[17] ? 17'(-dy) : dy[16:0];
    nx_full = adx * scale_x_q;
    ny_full = ady * scale_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sx0_q         <= screen_x_i;
    sy0_q         <= screen_y_i;
    dist0_q       <= distance_i;
    nx1_q         <= nx_full[CNUM_W-1:0];
    ny1_q         <= ny_full[CNUM_W-1:0];
    side1_q.sgn_x <= dx[17];
    side1_q.sgn_y <= dy[17];
    side1_q.reach <= dist0_q;
  end

  // ---------------- camera-space divide by the half sizes
  logic              cdx_v, cdy_v;
  logic [CNUM_W-1:0] qx, qy;
  cside_t            cd_dl_q [CDIV_STAGES];

  stwr_cam_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .num_i   (nx1_q),
    .den_i   (hw),
    .valid_o (cdx_v),
    .quo_o   (qx)
  );

  stwr_cam_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .num_i   (ny1_q),
    .den_i   (hh),
    .valid_o (cdy_v),
    .quo_o   (qy)
  );

  always_ff @(posedge clk_i) begin
    cd_dl_q[0] <= side1_q;
    for (int k = 1; k < CDIV_STAGES; k++) begin
      cd_dl_q[k] <= cd_dl_q[k-1];
    end
  end

  cside_t cd_side;
  assign cd_side = cd_dl_q[CDIV_STAGES-1];

  // ---------------- W1: rotation products
  logic signed [CNUM_W:0]   camx, camy;
  logic signed [ELEM_W-1:0] e [3][3];
  logic signed [CNUM_W+ELEM_W-1:0] p0_q [3], p1_q [3];
  logic              v_w_q [8];
  logic [DIST_W-1:0] dist_w_q [8];

  always_comb begin
    camx = cd_side.sgn_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    camy = cd_side.sgn_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[i][j] = $signed(row_q[i][ELEM_W*j +: ELEM_W]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      p0_q[j] <= camx * e[0][j];
      p1_q[j] <= camy * e[1][j];
    end
  end

  // ---------------- W2: world vector sums
  logic signed [WORLD_W-1:0] world_q [3];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      world_q[j] <= WORLD_W'(p0_q[j]) + WORLD_W'(p1_q[j])
                  + (WORLD_W'(e[2][j]) <<< 16);
    end
  end

  // ---------------- W3: magnitudes, signs, joint OR for the leading one
  logic [2:0][MAG_W-1:0] mag3_q, mag4_q, mag5_q;
  logic [2:0]            sgn_w_q [2:7];
  logic [MAG_W-1:0]      or3_q;
  logic [2:0][MAG_W-1:0] mag_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag_c[j] = world_q[j][WORLD_W-1] ? MAG_W'(-world_q[j]) : MAG_W'(world_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    mag3_q <= mag_c;
    or3_q  <= mag_c[0] | mag_c[1] | mag_c[2];
  end

  // ---------------- W4: coarse leading-one search over bytes
  logic [55:0] or_pad;
  logic [2:0]  chunk_c;
  logic [2:0]  chunk4_q;
  logic [7:0]  byte4_q;

  always_comb begin
    or_pad  = 56'(or3_q);
    chunk_c = '0;
    for (int c = 0; c < 7; c++) begin
      if (or_pad[8*c +: 8] != 8'd0) chunk_c = 3'(c);
    end
  end

  always_ff @(posedge clk_i) begin
    mag4_q   <= mag3_q;
    chunk4_q <= chunk_c;
    byte4_q  <= or_pad[{chunk_c, 3'b000} +: 8];
  end

  // ---------------- W5: fine search, block shift amount
  logic [2:0] bitpos_c;
  logic [5:0] msb_c;
  logic [4:0] shr_c, shl_c, shr5_q, shl5_q;

  always_comb begin
    bitpos_c = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte4_q[b]) bitpos_c = 3'(b);
    end
    msb_c = {chunk4_q, bitpos_c};
    if (msb_c >= 6'd31) begin
      shr_c = 5'(msb_c - 6'd30);
      shl_c = '0;
    end else begin
      shr_c = '0;
      shl_c = 5'(6'd30 - msb_c);
    end
  end

  always_ff @(posedge clk_i) begin
    mag5_q <= mag4_q;
    shr5_q <= shr_c;
    shl5_q <= shl_c;
  end

  // ---------------- W6: apply block shift
  logic [2:0][SM_W-1:0] sm6_q, sm7_q, sm8_q;
  logic [SM_W-1:0]      sm_or;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      sm6_q[j] <= SM_W'((mag5_q[j] >> shr5_q) << shl5_q);
    end
  end

  assign sm_or = sm6_q[0] | sm6_q[1] | sm6_q[2];

  // ---------------- W7: squares
  logic [2*SM_W-1:0] sq7_q [3];

  always_ff @(posedge clk_i) begin
    sm7_q <= sm6_q;
    for (int j = 0; j < 3; j++) begin
      sq7_q[j] <= sm6_q[j] * sm6_q[j];
    end
  end

  // ---------------- W8: sum of squares
  logic [SQ_W-1:0] sum8_q;

  always_ff @(posedge clk_i) begin
    sm8_q  <= sm7_q;
    sum8_q <= SQ_W'(sq7_q[0]) + SQ_W'(sq7_q[1]) + SQ_W'(sq7_q[2]);
  end

  // valid, distance and sign travel with the vector stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) v_w_q[k] <= 1'b0;
    end else begin
      v_w_q[0] <= cdx_v && cdy_v;
      for (int k = 1; k < 8; k++) v_w_q[k] <= v_w_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dist_w_q[0] <= cd_side.reach;
    for (int k = 1; k < 8; k++) dist_w_q[k] <= dist_w_q[k-1];
    for (int j = 0; j < 3; j++) sgn_w_q[2][j] <= world_q[j][WORLD_W-1];
    for (int k = 3; k < 8; k++) sgn_w_q[k] <= sgn_w_q[k-1];
  end

  // ---------------- square root
  logic             sq_v;
  logic [LEN_W-1:0] len;
  sside_t           sq_dl_q [SQRT_STAGES];
  sside_t           sq_side_in;

  assign sq_side_in = '{sgn: sgn_w_q[7], sm: sm8_q, reach: dist_w_q[7]};

  stwr_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_w_q[7]),
    .sum_i   (sum8_q),
    .valid_o (sq_v),
    .len_o   (len)
  );

  always_ff @(posedge clk_i) begin
    sq_dl_q[0] <= sq_side_in;
    for (int k = 1; k < SQRT_STAGES; k++) sq_dl_q[k] <= sq_dl_q[k-1];
  end

  sside_t sq_side;
  assign sq_side = sq_dl_q[SQRT_STAGES-1];

  // ---------------- direction divide
  logic                 dd_v;
  logic [2:0][DQ_W-1:0] dq;
  logic [LEN_W-1:0]     len_nz;
  dside_t               dd_dl_q [DDIV_STAGES];

  assign len_nz = (len == '0) ? LEN_W'(1) : len;

  stwr_dir_div u_ddiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .mag_i   (sq_side.sm),
    .den_i   (len_nz),
    .valid_o (dd_v),
    .quo_o   (dq)
  );

  always_ff @(posedge clk_i) begin
    dd_dl_q[0] <= '{sgn: sq_side.sgn, reach: sq_side.reach};
    for (int k = 1; k < DDIV_STAGES; k++) dd_dl_q[k] <= dd_dl_q[k-1];
  end

  dside_t dd_side;
  assign dd_side = dd_dl_q[DDIV_STAGES-1];

  // ---------------- P1: limit direction, offset product
  logic                         vp1_q;
  logic [2:0][DIR_W-2:0]        d1_q;
  logic [2:0]                   sgn1_q;
  logic [DIR_W-1+DIST_W-1:0]    prod1_q [3];
  logic [2:0][DIR_W-2:0]        d_lim;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_lim[j] = dq[j][DQ_W-1] ? {(DIR_W-1){1'b1}} : dq[j][DIR_W-2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q   <= d_lim;
    sgn1_q <= dd_side.sgn;
    for (int j = 0; j < 3; j++) begin
      prod1_q[j] <= d_lim[j] * dd_side.reach;
    end
  end

  // ---------------- P2: add camera position, saturate
  logic                     done_q;
  logic signed [DIR_W-1:0]  dir_q [3];
  logic signed [POS_W-1:0]  pt_q  [3];
  logic signed [POS_W+1:0]  psum  [3];
  logic signed [POS_W-1:0]  psat  [3];
  logic signed [DIR_W-1:0]  dsg   [3];

  always_comb begin
    logic [POS_W-1:0] off;
    for (int j = 0; j < 3; j++) begin
      off     = prod1_q[j][DIR_W-1+DIST_W-1:DIR_W-1];
      psum[j] = (POS_W+2)'($signed(cpos_q[POS_W*j +: POS_W]));
      if (sgn1_q[j]) begin
        psum[j] = psum[j] - $signed({2'b00, off});
        dsg[j]  = -$signed({1'b0, d1_q[j]});
      end else begin
        psum[j] = psum[j] + $signed({2'b00, off});
        dsg[j]  = $signed({1'b0, d1_q[j]});
      end
      if (psum[j] > (POS_W+2)'(524287)) begin
        psat[j] = 20'sh7FFFF;
      end else if (psum[j] < -(POS_W+2)'(524288)) begin
        psat[j] = 20'sh80000;
      end else begin
        psat[j] = psum[j][POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vp1_q  <= dd_v;
      done_q <= vp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      dir_q[j] <= dsg[j];
      pt_q[j]  <= psat[j];
    end
  end

  assign done_o    = done_q;
  assign dir_x_o   = dir_q[0];
  assign dir_y_o   = dir_q[1];
  assign dir_z_o   = dir_q[2];
  assign point_x_o = pt_q[0];
  assign point_y_o = pt_q[1];
  assign point_z_o = pt_q[2];

  // ---------------- checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without matching command");

  a_block_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_w_q[5] |-> (sm_or[SM_W-1] || sm_or == '0))
    else $error("block scaling left leading one out of place");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v |-> (len[LEN_W-1:LEN_W-2] != 2'b00 || len == '0))
    else $error("vector length out of range");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dd_v |-> (dq[0] <= 16'd32768 && dq[1] <= 16'd32768 && dq[2] <= 16'd32768))
    else $error("direction quotient above one");

endmodule
